// ===== rtl/core/fccw_pkg.sv =====
// ----------------------------------------------------------------------------
// fccw_pkg - FAT32 cluster chain walker package
// Request and response types, status codes and FAT32 entry constants.
// ----------------------------------------------------------------------------
package fccw_pkg;

    localparam int CLUSTER_W = 12;
    localparam int COUNT_W   = 13;
    localparam int ENTRY_W   = 28;
    localparam int RAW_W     = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WALK = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_LOOP    = 2'd2;

    localparam logic [ENTRY_W-1:0] LAST_LINK     = 28'hFFFFFEF;
    localparam logic [ENTRY_W-1:0] EOC_LOW       = 28'hFFFFFF8;
    localparam logic [ENTRY_W-1:0] FIRST_CLUSTER = 28'd2;

    localparam logic [COUNT_W-1:0] ENTRIES_RESET = 13'd4096;

    typedef struct packed {
        logic                 command;
        logic [CLUSTER_W-1:0] cluster_number;
        logic [RAW_W-1:0]     entry_value;
    } request_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   chain_length;
        logic [CLUSTER_W-1:0] last_cluster;
        logic [1:0]           status;
    } response_t;

    // classification of one table entry against the current limit
    typedef struct packed {
        logic eoc;
        logic link_ok;
    } link_class_t;

endpackage

// ===== rtl/core/fccw_ram.sv =====
// ----------------------------------------------------------------------------
// fccw_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fccw_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fccw_link_check.sv =====
// ----------------------------------------------------------------------------
// fccw_link_check - table entry classifier
// Flags an end-of-chain marker or a usable next-cluster link.
// ----------------------------------------------------------------------------
module fccw_link_check (
    input  logic [fccw_pkg::ENTRY_W-1:0] entry,
    input  logic [fccw_pkg::COUNT_W-1:0] limit,
    output fccw_pkg::link_class_t        cls
);
    import fccw_pkg::*;

    always_comb
    begin
        cls.eoc     = (entry >= EOC_LOW);
        cls.link_ok = (entry >= FIRST_CLUSTER) && (entry <= LAST_LINK)
                      && (entry < {{(ENTRY_W-COUNT_W){1'b0}}, limit});
    end

endmodule

// ===== rtl/core/fat32_cluster_chain_walker.sv =====
// ----------------------------------------------------------------------------
// fat32_cluster_chain_walker - FAT32 cluster chain walker
// Local allocation table with a sequencer that follows next-cluster links.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. A load request
//   writes the low 28 bits of entry_value into the table and gives no
//   response; busy stays low, so loads go one per cycle while no walk is busy.
//   A walk request starts at cluster_number and follows links through the
//   table. The start address goes to the table RAM in the request cycle, so
//   the first cluster is checked in the next cycle. Each further cluster
//   takes a fetch state to present the address to the table RAM and a
//   check state for the registered read and the link check. A walk holds
//   busy high until it raises done in the cycle after the last check; a
//   bad start cluster gives done in the cycle after the request. Links
//   are followed one at a time through the table RAM read port and the
//   single link checker.
//   The response is on response for exactly one cycle with done high; the
//   receiver must take it then, as it cannot stall the block.
//   cfg_we/cfg_wdata write entries_in_use; write only while idle.
//   Reset clears the sequencer and sets entries_in_use to 4096. The table
//   is not cleared: entries must be loaded before a walk reaches them.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_walker #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fccw_pkg::request_t           request,
    output logic                         done,
    output fccw_pkg::response_t          response,
    input  logic                         cfg_we,
    input  logic [fccw_pkg::COUNT_W-1:0] cfg_wdata
);
    import fccw_pkg::*;

    localparam int AW        = $clog2(TABLE_DEPTH);
    localparam int DEPTH_CAP = (TABLE_DEPTH > 8191) ? 8191 : TABLE_DEPTH;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] entries_reg;
    logic [COUNT_W-1:0] cur_reg, cur_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    response_t          resp_reg, resp_next;

    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] start_cl;
    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    link_class_t        cls;

    assign limit    = (entries_reg > COUNT_W'(DEPTH_CAP)) ? COUNT_W'(DEPTH_CAP)
                                                          : entries_reg;
    assign start_cl = {1'b0, request.cluster_number};
    assign accept   = start && !busy;
    assign ram_we   = accept && (request.command == CMD_LOAD)
                      && (32'(request.cluster_number) < 32'(TABLE_DEPTH));
    // walk start is read straight from the request, later links from cur
    assign ram_raddr = (state_reg == S_IDLE) ? AW'(start_cl) : AW'(cur_reg);

    fccw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(request.cluster_number)),
        .wdata (request.entry_value[ENTRY_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fccw_link_check u_check (
        .entry (ram_rdata),
        .limit (limit),
        .cls   (cls)
    );

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        resp_next  = resp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (request.command == CMD_WALK))
                begin
                    cur_next   = start_cl;
                    count_next = COUNT_W'(1);
                    if ((start_cl < COUNT_W'(FIRST_CLUSTER)) || (start_cl >= limit))
                    begin
                        done_next              = 1'b1;
                        resp_next.chain_length = '0;
                        resp_next.last_cluster = request.cluster_number;
                        resp_next.status       = ST_INVALID;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                resp_next.chain_length = count_reg;
                resp_next.last_cluster = cur_reg[CLUSTER_W-1:0];
                if (cls.eoc)
                begin
                    done_next        = 1'b1;
                    resp_next.status = ST_OK;
                    state_next       = S_IDLE;
                end
                else if (cls.link_ok && (count_reg < limit))
                begin
                    cur_next   = ram_rdata[COUNT_W-1:0];
                    count_next = count_reg + COUNT_W'(1);
                    state_next = S_FETCH;
                end
                else
                begin
                    done_next        = 1'b1;
                    resp_next.status = cls.link_ok ? ST_LOOP : ST_INVALID;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            entries_reg <= ENTRIES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        count_reg <= count_next;
        resp_reg  <= resp_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign response = resp_reg;

    // a response follows either a walk request or a walk in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && (request.command == CMD_WALK))))
        else $error("response without a walk");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("response while still walking");

    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == ST_OK)) |-> (response.chain_length != '0))
        else $error("completed chain with zero length");

    a_loop_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (response.status == ST_LOOP)) |-> (response.chain_length == limit))
        else $error("loop reported below the limit");

endmodule
